/* src/mbcd_pkg.sv */
// Shared types, constants and layout table for the meter BCD value field decoder.
package mbcd_pkg;

  // Number of field byte inputs, fixed by the input word.
  localparam int IN_BYTES = 6;
  // Longest field layout the decoder accepts.
  localparam int MAX_FIELD_BYTES = 6;

  localparam logic [7:0] INVALID_MARK = 8'hee;
  localparam logic [7:0] MASK_BIT4 = 8'h0f;
  localparam logic [7:0] MASK_BIT7 = 8'h7f;
  localparam logic [7:0] MASK_NONE = 8'hff;

  // Status codes of a result word.
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_INVALID = 3'd1;
  localparam logic [2:0] ST_NONBCD  = 3'd2;
  localparam logic [2:0] ST_SHORT   = 3'd3;
  localparam logic [2:0] ST_UNKNOWN = 3'd4;

  // Sign position codes.
  localparam logic [1:0] SIGN_NONE = 2'd0;
  localparam logic [1:0] SIGN_BIT4 = 2'd1;
  localparam logic [1:0] SIGN_BIT7 = 2'd2;

  // Format code with a data-dependent exponent.
  localparam logic [3:0] CODE_GEXP = 4'd0;

  // Weight of the digit pair in each byte position.
  localparam logic [39:0] POW100 [IN_BYTES] = '{
    40'd1, 40'd100, 40'd10000, 40'd1000000, 40'd100000000, 40'd10000000000
  };

  typedef struct packed {
    logic [2:0]        len;
    logic signed [3:0] expo;
    logic [1:0]        sign;
  } layout_t;

  // What one byte lane reports to the merge stage.
  typedef struct packed {
    logic        invalid;
    logic        nonbcd;
    logic [7:0]  top_byte;
    logic [39:0] term;
  } lane_res_t;

  // Per-word control carried alongside the lane results.
  typedef struct packed {
    logic [3:0] code;
    logic [2:0] len;
    logic [1:0] sign;
    logic       shrt;
    logic       unknown;
  } word_ctl_t;

  // One finished result word.
  typedef struct packed {
    logic [39:0]       magnitude;
    logic              is_negative;
    logic signed [3:0] decimal_exponent;
    logic [2:0]        status;
    logic [2:0]        bytes_used;
  } result_t;

  // Field layout for each format code.
  function automatic layout_t layout_of(input logic [3:0] code);
    layout_t l;
    case (code)
      4'd0:    l = '{3'd2, -4'sd4, SIGN_BIT4};
      4'd1:    l = '{3'd4,  4'sd0, SIGN_BIT4};
      4'd2:    l = '{3'd2,  4'sd0, SIGN_BIT7};
      4'd3:    l = '{3'd2, -4'sd1, SIGN_BIT7};
      4'd4:    l = '{3'd2, -4'sd2, SIGN_BIT7};
      4'd5:    l = '{3'd2, -4'sd1, SIGN_NONE};
      4'd6:    l = '{3'd2,  4'sd0, SIGN_NONE};
      4'd7:    l = '{3'd3, -4'sd4, SIGN_BIT7};
      4'd8:    l = '{3'd3,  4'sd0, SIGN_NONE};
      4'd9:    l = '{3'd4, -4'sd2, SIGN_NONE};
      4'd10:   l = '{3'd6,  4'sd0, SIGN_NONE};
      4'd11:   l = '{3'd4, -4'sd4, SIGN_NONE};
      4'd12:   l = '{3'd5, -4'sd4, SIGN_NONE};
      4'd13:   l = '{3'd1, -4'sd1, SIGN_NONE};
      4'd14:   l = '{3'd3, -4'sd4, SIGN_NONE};
      4'd15:   l = '{3'd3, -4'sd3, SIGN_BIT7};
      default: l = '{3'd0,  4'sd0, SIGN_NONE};
    endcase
    return l;
  endfunction

endpackage

/* src/mbcd_if.sv */
// Handshake interfaces for the field input words and the result words.
interface mbcd_field_if;
  logic       valid;
  logic       ready;
  logic [3:0] format_code;
  logic [2:0] bytes_available;
  logic [7:0] field_byte_0;
  logic [7:0] field_byte_1;
  logic [7:0] field_byte_2;
  logic [7:0] field_byte_3;
  logic [7:0] field_byte_4;
  logic [7:0] field_byte_5;

  modport source (
    output valid, format_code, bytes_available,
    output field_byte_0, field_byte_1, field_byte_2,
    output field_byte_3, field_byte_4, field_byte_5,
    input  ready
  );
  modport sink (
    input  valid, format_code, bytes_available,
    input  field_byte_0, field_byte_1, field_byte_2,
    input  field_byte_3, field_byte_4, field_byte_5,
    output ready
  );
endinterface

interface mbcd_result_if;
  logic              valid;
  logic              ready;
  logic [39:0]       magnitude;
  logic              is_negative;
  logic signed [3:0] decimal_exponent;
  logic [2:0]        status;
  logic [2:0]        bytes_used;

  modport source (
    output valid, magnitude, is_negative, decimal_exponent, status, bytes_used,
    input  ready
  );
  modport sink (
    input  valid, magnitude, is_negative, decimal_exponent, status, bytes_used,
    output ready
  );
endinterface

/* src/meter_bcd_value_field_decoder_top.sv */
// Top level of the meter BCD value field decoder.
//
// The field channel carries one word per value field: the format code, the
// count of bytes present and six field bytes, lowest byte first. The result
// channel returns one word per field: the binary magnitude, sign flag,
// decimal exponent, status and the number of field bytes consumed.
// Both channels use a valid/ready handshake; a word moves when both are high.
//
// A field word is decoded in two register stages: six byte lanes mask, check
// and weight their byte in the first, and the merge stage sums the lane
// terms and resolves the status in the second, whose register drives the
// result channel. A word passes the first stage register, then the result
// register. A new field word is taken every cycle while results drain.
//
// When the receiver holds ready low, the result register keeps its word and
// the first stage fills up; field ready then drops until the result moves.
// Reset empties both stages; there is no other state.
module meter_bcd_value_field_decoder_top
  import mbcd_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  mbcd_field_if.sink    field,
  mbcd_result_if.source result
);

  logic [7:0] field_bytes [IN_BYTES];
  lane_res_t  lane_out [IN_BYTES];
  lane_res_t  s1_lanes [IN_BYTES];
  layout_t    lay;
  word_ctl_t  ctl_next;
  word_ctl_t  s1_ctl;
  logic       s1_valid;
  result_t    merged;
  result_t    out_word;
  logic       out_valid;
  logic       out_free;
  logic       s1_move;

  assign field_bytes[0] = field.field_byte_0;
  assign field_bytes[1] = field.field_byte_1;
  assign field_bytes[2] = field.field_byte_2;
  assign field_bytes[3] = field.field_byte_3;
  assign field_bytes[4] = field.field_byte_4;
  assign field_bytes[5] = field.field_byte_5;

  // Layout lookup and the length checks.
  assign lay = layout_of(field.format_code);

  always_comb begin
    ctl_next.code    = field.format_code;
    ctl_next.len     = lay.len;
    ctl_next.sign    = lay.sign;
    ctl_next.unknown = (4'(lay.len) > 4'(MAX_FIELD_BYTES)) || (lay.len == 3'd0);
    ctl_next.shrt    = field.bytes_available < lay.len;
  end

  // Byte lanes.
  for (genvar i = 0; i < IN_BYTES; i++) begin : g_lane
    mbcd_lane u_lane (
      .lane_idx (3'(i)),
      .byte_in  (field_bytes[i]),
      .len      (lay.len),
      .sign     (lay.sign),
      .res      (lane_out[i])
    );
  end

  // Pipeline flow control.
  assign out_free    = !out_valid || result.ready;
  assign s1_move     = s1_valid && out_free;
  assign field.ready = !s1_valid || out_free;

  // First stage register: lane reports and word control.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (field.ready) begin
      s1_valid <= field.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (field.ready && field.valid) begin
      s1_ctl   <= ctl_next;
      s1_lanes <= lane_out;
    end
  end

  // Merge stage.
  mbcd_merge u_merge (
    .ctl   (s1_ctl),
    .lanes (s1_lanes),
    .res   (merged)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_word <= merged;
    end
  end

  assign result.valid            = out_valid;
  assign result.magnitude        = out_word.magnitude;
  assign result.is_negative      = out_word.is_negative;
  assign result.decimal_exponent = out_word.decimal_exponent;
  assign result.status           = out_word.status;
  assign result.bytes_used       = out_word.bytes_used;

endmodule

/* src/mbcd_lane.sv */
// One byte lane: masks, checks and weights one field byte.
module mbcd_lane
  import mbcd_pkg::*;
(
  input  logic [2:0] lane_idx,
  input  logic [7:0] byte_in,
  input  logic [2:0] len,
  input  logic [1:0] sign,
  output lane_res_t  res
);

  logic       active;
  logic       is_top;
  logic [7:0] mask;
  logic [7:0] masked;
  logic [6:0] pair;

  // Lane position relative to the field length.
  assign active = lane_idx < len;
  assign is_top = active && (lane_idx == len - 3'd1);

  // The top byte loses its sign and exponent bits before the digit check.
  always_comb begin
    mask = MASK_NONE;
    if (is_top) begin
      case (sign)
        SIGN_BIT4: mask = MASK_BIT4;
        SIGN_BIT7: mask = MASK_BIT7;
        default:   mask = MASK_NONE;
      endcase
    end
  end

  assign masked = byte_in & mask;
  assign pair   = 7'(masked[7:4]) * 7'd10 + 7'(masked[3:0]);

  // Lane report; inactive lanes contribute nothing.
  always_comb begin
    res.invalid  = active && (byte_in == INVALID_MARK);
    res.nonbcd   = active && ((masked[3:0] > 4'd9) || (masked[7:4] > 4'd9));
    res.top_byte = is_top ? byte_in : 8'd0;
    res.term     = active ? 40'(40'(pair) * POW100[lane_idx]) : 40'd0;
  end

endmodule

/* src/mbcd_merge.sv */
// Merge stage: combines the lane reports into one result word.
module mbcd_merge
  import mbcd_pkg::*;
(
  input  word_ctl_t ctl,
  input  lane_res_t lanes [IN_BYTES],
  output result_t   res
);

  logic        any_invalid;
  logic        any_nonbcd;
  logic [7:0]  top;
  logic [39:0] sum;
  logic        neg;
  logic signed [3:0] expo;
  layout_t     lay;

  // Reduce the lanes: flags and top byte by OR, digit terms by sum.
  always_comb begin
    any_invalid = 1'b0;
    any_nonbcd  = 1'b0;
    top         = 8'd0;
    sum         = 40'd0;
    for (int i = 0; i < IN_BYTES; i++) begin
      any_invalid = any_invalid | lanes[i].invalid;
      any_nonbcd  = any_nonbcd | lanes[i].nonbcd;
      top         = top | lanes[i].top_byte;
      sum         = sum + lanes[i].term;
    end
  end

  // Sign and exponent from the top byte and the layout.
  assign lay = layout_of(ctl.code);

  always_comb begin
    case (ctl.sign)
      SIGN_BIT4: neg = top[4];
      SIGN_BIT7: neg = top[7];
      default:   neg = 1'b0;
    endcase
    if (ctl.code == CODE_GEXP) begin
      expo = signed'(4'({1'b0, top[7:5]}) - 4'd4);
    end else begin
      expo = lay.expo;
    end
  end

  // Checks in priority order.
  always_comb begin
    res = '0;
    if (ctl.unknown) begin
      res.status = ST_UNKNOWN;
    end else if (ctl.shrt) begin
      res.status = ST_SHORT;
    end else if (any_invalid) begin
      res.status     = ST_INVALID;
      res.bytes_used = ctl.len;
    end else if (any_nonbcd) begin
      res.status = ST_NONBCD;
    end else begin
      res.status           = ST_OK;
      res.magnitude        = sum;
      res.is_negative      = neg;
      res.decimal_exponent = expo;
      res.bytes_used       = ctl.len;
    end
  end

endmodule
